// ===== rtl/alp_pkg.sv =====
// alp_pkg: shared constants, codes and controller/datapath types for the
// loop playhead. No dependencies.
`timescale 1ns / 1ps
package alp_pkg;

    localparam int MEM_DEPTH_DEF = 65536;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 16;
    localparam int IDX_W      = 16;
    localparam int END_W      = 17;
    localparam int SPEED_W    = 24;
    localparam int POS_W      = 33;
    localparam int SR_W       = 18;
    localparam int TEMPO_W    = 18;
    localparam int BEAT_W     = 32;
    localparam int KIND_W     = 2;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int ADDR_X_W   = 25;  // covers the largest memory depth
    localparam int DIV_NUM_W  = 64;
    localparam int DIV_DEN_W  = 34;
    localparam int DIV_CNT_W  = 7;

    // 60 s/min * 256 sub-beats = 15360
    localparam int BEAT_SCALE = 15360;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_ALIGN  = 2'd2,
        KIND_REWIND = 2'd3
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] REG_LOOP_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_END    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAN         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd6;

    localparam logic [SPEED_W-1:0] RST_SPEED       = 24'd65536;
    localparam logic [15:0]        RST_LEVEL       = 16'd32768;
    localparam logic [SR_W-1:0]    RST_SAMPLE_RATE = 18'd48000;

    localparam int MODE_STEREO = 0;
    localparam int MODE_SYNC   = 1;
    localparam int MODE_REV    = 2;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LATCH,
        OP_LOAD,
        OP_REWIND,
        OP_CHECK,
        OP_RD_A,
        OP_RD_B,
        OP_CAP_B,
        OP_INTERP,
        OP_GAIN1,
        OP_GAIN2,
        OP_ADV,
        OP_WRAP,
        OP_OUT,
        OP_T_MUL1,
        OP_T_MUL2,
        OP_T_DIV1,
        OP_T_DIV2,
        OP_T_DIV3,
        OP_T_SET
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  empty;
        logic  sync_ok;
        logic  need_wrap;
        logic  div_busy;
    } status_t;

endpackage

// ===== rtl/alp_if.sv =====
// alp_if: valid/ready channel interfaces for requests, results and config.
// Depends on alp_pkg for field widths.
`timescale 1ns / 1ps
interface alp_in_if;
    logic                                valid;
    logic                                ready;
    logic [alp_pkg::KIND_W-1:0]          kind;
    logic [alp_pkg::IDX_W-1:0]           load_index;
    logic signed [alp_pkg::SAMPLE_W-1:0] load_left;
    logic signed [alp_pkg::SAMPLE_W-1:0] load_right;
    logic [alp_pkg::BEAT_W-1:0]          beat_position;
    logic [alp_pkg::TEMPO_W-1:0]         tempo;

    modport source (output valid, kind, load_index, load_left, load_right,
                    beat_position, tempo, input ready);
    modport sink   (input valid, kind, load_index, load_left, load_right,
                    beat_position, tempo, output ready);
endinterface

interface alp_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [alp_pkg::SAMPLE_W-1:0] out_left;
    logic signed [alp_pkg::SAMPLE_W-1:0] out_right;

    modport source (output valid, out_left, out_right, input ready);
    modport sink   (input valid, out_left, out_right, output ready);
endinterface

interface alp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [alp_pkg::CFG_IDX_W-1:0]     index;
    logic [alp_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/alp_div.sv =====
// alp_div: restoring divider, one quotient bit per cycle.
// Depends on alp_pkg for widths.
`timescale 1ns / 1ps
module alp_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [alp_pkg::DIV_NUM_W-1:0]   num_in,
    input  logic [alp_pkg::DIV_DEN_W-1:0]   rem_in,
    input  logic [alp_pkg::DIV_DEN_W-1:0]   den_in,
    input  logic [alp_pkg::DIV_CNT_W-1:0]   n_in,
    output logic                            busy,
    output logic [alp_pkg::DIV_NUM_W-1:0]   quo,
    output logic [alp_pkg::DIV_DEN_W-1:0]   rem
);
    localparam int NW = alp_pkg::DIV_NUM_W;
    localparam int DW = alp_pkg::DIV_DEN_W;

    logic [NW-1:0]               num_reg;
    logic [DW-1:0]               rem_reg;
    logic [DW-1:0]               den_reg;
    logic [alp_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                        busy_reg;
    logic [DW:0]                 trial;
    logic [DW:0]                 diff;
    logic                        ge;

    // dividend bits enter from the top of num_reg, quotient bits from below
    assign trial = {rem_reg, num_reg[NW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= n_in;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 7'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num_in;
            rem_reg <= rem_in;
            den_reg <= den_in;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            num_reg <= {num_reg[NW-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quo  = num_reg;
    assign rem  = rem_reg;
endmodule

// ===== rtl/alp_datapath.sv =====
// alp_datapath: config registers, frame memory, play position, interpolation,
// gain and wrap/align arithmetic. Depends on alp_pkg and alp_div.
`timescale 1ns / 1ps
module alp_datapath #(
    parameter int MEM_DEPTH = alp_pkg::MEM_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  alp_pkg::cmd_t                       cmd,
    output alp_pkg::status_t                    status,
    input  logic                                cfg_we,
    input  logic [alp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [alp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [alp_pkg::KIND_W-1:0]          kind,
    input  logic [alp_pkg::IDX_W-1:0]           load_index,
    input  logic signed [alp_pkg::SAMPLE_W-1:0] load_left,
    input  logic signed [alp_pkg::SAMPLE_W-1:0] load_right,
    input  logic [alp_pkg::BEAT_W-1:0]          beat_position,
    input  logic [alp_pkg::TEMPO_W-1:0]         tempo,
    output logic signed [alp_pkg::SAMPLE_W-1:0] out_left,
    output logic signed [alp_pkg::SAMPLE_W-1:0] out_right
);
    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int XW = alp_pkg::ADDR_X_W;
    localparam logic [XW-1:0] DEPTH_X = XW'(MEM_DEPTH);
    localparam int PW = alp_pkg::POS_W;
    localparam int SW = alp_pkg::SAMPLE_W;
    localparam logic signed [21:0] SH_MAX = 22'sd32767;
    localparam logic signed [21:0] SH_MIN = -22'sd32768;

    // configuration
    logic [15:0]                      loop_start_reg;
    logic [alp_pkg::END_W-1:0]        loop_end_reg;
    logic [alp_pkg::SPEED_W-1:0]      speed_reg;
    logic signed [15:0]               pan_reg;
    logic [15:0]                      level_reg;
    logic [alp_pkg::SR_W-1:0]         sample_rate_reg;
    logic [alp_pkg::MODE_W-1:0]       mode_reg;

    // latched request
    alp_pkg::kind_t                   kind_reg;
    logic [alp_pkg::IDX_W-1:0]        idx_reg;
    logic signed [SW-1:0]             ll_reg;
    logic signed [SW-1:0]             lr_reg;
    logic [alp_pkg::BEAT_W-1:0]       beat_reg;
    logic [alp_pkg::TEMPO_W-1:0]      tempo_reg;

    logic [PW-1:0]                    pos_reg;

    logic [31:0]                      mem [MEM_DEPTH];
    logic [31:0]                      rdata_reg;
    logic                             rd_zero_reg;

    logic signed [SW-1:0]             a_l_reg, a_r_reg, b_l_reg, b_r_reg;
    logic signed [33:0]               prod_l_reg, prod_r_reg;
    logic signed [34:0]               vg_l_reg, vg_r_reg;
    logic signed [51:0]               t_l_reg, t_r_reg;
    logic signed [SW-1:0]             out_l_reg, out_r_reg;
    logic                             wrap_rev_reg;
    logic [31:0]                      k_reg;
    logic [63:0]                      x_reg;
    logic [alp_pkg::DIV_DEN_W-1:0]    r_reg;
    logic [alp_pkg::END_W-1:0]        offi_reg;

    // combinational
    logic [PW-1:0]                    s_pos, e_pos, l_pos;
    logic                             empty;
    logic [alp_pkg::END_W-1:0]        i_idx, i1_raw, i1_idx, rd_idx, span;
    logic [XW-1:0]                    rd_x, wr_x;
    logic [15:0]                      f_pos;
    logic [PW-1:0]                    step, fwd, off, rev_val, under, adv_val, wrap_num;
    logic                             rev, rev_ok, need_wrap;
    logic signed [SW-1:0]             rd_l, rd_r;
    logic signed [16:0]               diff_l, diff_r, f_s;
    logic signed [33:0]               prod_l_c, prod_r_c;
    logic signed [16:0]               v_l, v_r;
    logic [16:0]                      g_l, g_r;
    logic signed [34:0]               vg_l_c, vg_r_c;
    logic signed [51:0]               t_l_c, t_r_c;
    logic signed [21:0]               sh_l, sh_r;
    logic signed [SW-1:0]             sat_l, sat_r;
    logic                             sync_ok;

    logic                             div_start, div_busy;
    logic [alp_pkg::DIV_NUM_W-1:0]    div_num, div_quo;
    logic [alp_pkg::DIV_DEN_W-1:0]    div_rem0, div_den, div_rem;
    logic [alp_pkg::DIV_CNT_W-1:0]    div_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_start_reg  <= '0;
            loop_end_reg    <= '0;
            speed_reg       <= alp_pkg::RST_SPEED;
            pan_reg         <= '0;
            level_reg       <= alp_pkg::RST_LEVEL;
            sample_rate_reg <= alp_pkg::RST_SAMPLE_RATE;
            mode_reg        <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                alp_pkg::REG_LOOP_START:  loop_start_reg  <= cfg_data[15:0];
                alp_pkg::REG_LOOP_END:    loop_end_reg    <= cfg_data[alp_pkg::END_W-1:0];
                alp_pkg::REG_SPEED:       speed_reg       <= cfg_data;
                alp_pkg::REG_PAN:         pan_reg         <= $signed(cfg_data[15:0]);
                alp_pkg::REG_LEVEL:       level_reg       <= cfg_data[15:0];
                alp_pkg::REG_SAMPLE_RATE: sample_rate_reg <= cfg_data[alp_pkg::SR_W-1:0];
                alp_pkg::REG_MODE:        mode_reg        <= cfg_data[alp_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == alp_pkg::OP_LATCH)
        begin
            kind_reg  <= alp_pkg::kind_t'(kind);
            idx_reg   <= load_index;
            ll_reg    <= load_left;
            lr_reg    <= load_right;
            beat_reg  <= beat_position;
            tempo_reg <= tempo;
        end
    end

    // loop geometry in position units
    assign s_pos   = {1'b0, loop_start_reg, 16'b0};
    assign e_pos   = {loop_end_reg, 16'b0};
    assign l_pos   = e_pos - s_pos;
    assign span    = loop_end_reg - {1'b0, loop_start_reg};
    assign empty   = loop_end_reg <= {1'b0, loop_start_reg};
    assign sync_ok = mode_reg[alp_pkg::MODE_SYNC] && !empty && (tempo_reg != '0)
                     && (sample_rate_reg != '0);

    assign i_idx  = pos_reg[PW-1:alp_pkg::FRAC_W];
    assign f_pos  = pos_reg[alp_pkg::FRAC_W-1:0];
    assign i1_raw = i_idx + 1'b1;
    assign i1_idx = (i1_raw >= loop_end_reg) ? {1'b0, loop_start_reg} : i1_raw;

    // advance
    assign step     = PW'(speed_reg);
    assign rev      = mode_reg[alp_pkg::MODE_REV];
    assign fwd      = pos_reg + step;
    assign off      = pos_reg - s_pos;
    assign rev_ok   = step <= off;
    assign rev_val  = pos_reg - step;
    assign under    = step - off;
    assign need_wrap = rev ? !rev_ok : (fwd >= e_pos);
    assign adv_val  = rev ? rev_val : fwd;
    assign wrap_num = rev ? under : (fwd - s_pos);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                alp_pkg::OP_REWIND: pos_reg <= s_pos;
                alp_pkg::OP_CHECK:
                begin
                    if (!empty && (pos_reg < s_pos || pos_reg >= e_pos))
                    begin
                        pos_reg <= s_pos;
                    end
                end
                alp_pkg::OP_ADV:
                begin
                    if (!need_wrap)
                    begin
                        pos_reg <= adv_val;
                    end
                end
                alp_pkg::OP_WRAP:
                    pos_reg <= wrap_rev_reg ? e_pos - div_rem[PW-1:0]
                                            : s_pos + div_rem[PW-1:0];
                alp_pkg::OP_T_SET:
                    pos_reg <= s_pos + {offi_reg, 16'b0} + PW'(div_quo[15:0]);
                default: ;
            endcase
        end
    end

    // frame memory: left in the upper half of a word
    assign rd_idx = (cmd.op == alp_pkg::OP_RD_A) ? i_idx : i1_idx;
    assign rd_x   = XW'(rd_idx);
    assign wr_x   = XW'(idx_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.op == alp_pkg::OP_LOAD && wr_x < DEPTH_X)
        begin
            mem[wr_x[AW-1:0]] <= {ll_reg, lr_reg};
        end
        rdata_reg <= mem[rd_x[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        rd_zero_reg <= !(rd_x < DEPTH_X);
    end

    assign rd_l = rd_zero_reg ? '0 : $signed(rdata_reg[31:16]);
    assign rd_r = rd_zero_reg ? '0 : $signed(rdata_reg[15:0]);

    // interpolation and gain
    assign f_s      = $signed({1'b0, f_pos});
    assign diff_l   = 17'(b_l_reg) - 17'(a_l_reg);
    assign diff_r   = 17'(b_r_reg) - 17'(a_r_reg);
    assign prod_l_c = diff_l * f_s;
    assign prod_r_c = diff_r * f_s;
    assign v_l      = 17'(a_l_reg) + $signed(prod_l_reg[32:16]);
    assign v_r      = 17'(a_r_reg) + $signed(prod_r_reg[32:16]);
    assign g_l      = pan_reg[15] ? 17'd32768 : 17'd32768 - {2'b0, pan_reg[14:0]};
    assign g_r      = pan_reg[15] ? 17'd32768 + {pan_reg[15], pan_reg} : 17'd32768;
    assign vg_l_c   = v_l * $signed({1'b0, g_l});
    assign vg_r_c   = v_r * $signed({1'b0, g_r});
    assign t_l_c    = vg_l_reg * $signed({1'b0, level_reg});
    assign t_r_c    = vg_r_reg * $signed({1'b0, level_reg});
    assign sh_l     = t_l_reg[51:30];
    assign sh_r     = t_r_reg[51:30];
    assign sat_l    = (sh_l > SH_MAX) ? SH_MAX[SW-1:0] :
                      (sh_l < SH_MIN) ? SH_MIN[SW-1:0] : sh_l[SW-1:0];
    assign sat_r    = (sh_r > SH_MAX) ? SH_MAX[SW-1:0] :
                      (sh_r < SH_MIN) ? SH_MIN[SW-1:0] : sh_r[SW-1:0];

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            alp_pkg::OP_RD_B:
            begin
                a_l_reg <= rd_l;
                a_r_reg <= mode_reg[alp_pkg::MODE_STEREO] ? rd_r : rd_l;
            end
            alp_pkg::OP_CAP_B:
            begin
                b_l_reg <= rd_l;
                b_r_reg <= mode_reg[alp_pkg::MODE_STEREO] ? rd_r : rd_l;
            end
            alp_pkg::OP_INTERP:
            begin
                prod_l_reg <= prod_l_c;
                prod_r_reg <= prod_r_c;
            end
            alp_pkg::OP_GAIN1:
            begin
                vg_l_reg <= vg_l_c;
                vg_r_reg <= vg_r_c;
            end
            alp_pkg::OP_GAIN2:
            begin
                t_l_reg <= t_l_c;
                t_r_reg <= t_r_c;
            end
            alp_pkg::OP_OUT:
            begin
                out_l_reg <= empty ? '0 : sat_l;
                out_r_reg <= empty ? '0 : sat_r;
            end
            alp_pkg::OP_ADV:   wrap_rev_reg <= rev;
            alp_pkg::OP_T_MUL1: k_reg <= 32'(sample_rate_reg) * 32'(alp_pkg::BEAT_SCALE);
            alp_pkg::OP_T_MUL2: x_reg <= {32'b0, beat_reg} * {32'b0, k_reg};
            alp_pkg::OP_T_DIV2: r_reg <= div_rem;
            alp_pkg::OP_T_DIV3: offi_reg <= div_rem[alp_pkg::END_W-1:0];
            default: ;
        endcase
    end

    // divider sharing: loop wrap, beat quotient, modulo span, fraction
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_rem0  = '0;
        div_den   = {tempo_reg, 16'b0};
        div_n     = 7'd64;
        case (cmd.op)
            alp_pkg::OP_ADV:
            begin
                div_start = need_wrap;
                div_num   = {wrap_num, 31'b0};
                div_den   = {1'b0, l_pos};
                div_n     = 7'd33;
            end
            alp_pkg::OP_T_DIV1:
            begin
                div_start = 1'b1;
                div_num   = x_reg;
            end
            alp_pkg::OP_T_DIV2:
            begin
                div_start = 1'b1;
                div_num   = {div_quo[47:0], 16'b0};
                div_den   = alp_pkg::DIV_DEN_W'(span);
                div_n     = 7'd48;
            end
            alp_pkg::OP_T_DIV3:
            begin
                div_start = 1'b1;
                div_rem0  = r_reg;
                div_n     = 7'd16;
            end
            default: ;
        endcase
    end

    alp_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num_in (div_num),
        .rem_in (div_rem0),
        .den_in (div_den),
        .n_in   (div_n),
        .busy   (div_busy),
        .quo    (div_quo),
        .rem    (div_rem)
    );

    assign status.kind      = kind_reg;
    assign status.empty     = empty;
    assign status.sync_ok   = sync_ok;
    assign status.need_wrap = need_wrap;
    assign status.div_busy  = div_busy;

    assign out_left  = out_l_reg;
    assign out_right = out_r_reg;
endmodule

// ===== rtl/alp_ctrl.sv =====
// alp_ctrl: sequencer for load, tick, align and rewind words.
// Depends on alp_pkg for command and status types.
`timescale 1ns / 1ps
module alp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  alp_pkg::status_t  status,
    output alp_pkg::cmd_t     cmd
);
    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOAD,
        S_REWIND,
        S_CHECK,
        S_RD_A,
        S_RD_B,
        S_CAP_B,
        S_INTERP,
        S_GAIN1,
        S_GAIN2,
        S_ADV,
        S_WRAP_WAIT,
        S_OUT,
        S_T_CHECK,
        S_T_MUL1,
        S_T_MUL2,
        S_T_DIV1,
        S_T_W1,
        S_T_W2,
        S_T_W3
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = alp_pkg::OP_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = alp_pkg::OP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.kind)
                    alp_pkg::KIND_LOAD:  state_next = S_LOAD;
                    alp_pkg::KIND_TICK:  state_next = S_CHECK;
                    alp_pkg::KIND_ALIGN: state_next = S_T_CHECK;
                    default:             state_next = S_REWIND;
                endcase
            end
            S_LOAD:
            begin
                cmd.op     = alp_pkg::OP_LOAD;
                state_next = S_IDLE;
            end
            S_REWIND:
            begin
                cmd.op     = alp_pkg::OP_REWIND;
                state_next = S_IDLE;
            end
            S_CHECK:
            begin
                cmd.op     = alp_pkg::OP_CHECK;
                state_next = status.empty ? S_OUT : S_RD_A;
            end
            S_RD_A:
            begin
                cmd.op     = alp_pkg::OP_RD_A;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                cmd.op     = alp_pkg::OP_RD_B;
                state_next = S_CAP_B;
            end
            S_CAP_B:
            begin
                cmd.op     = alp_pkg::OP_CAP_B;
                state_next = S_INTERP;
            end
            S_INTERP:
            begin
                cmd.op     = alp_pkg::OP_INTERP;
                state_next = S_GAIN1;
            end
            S_GAIN1:
            begin
                cmd.op     = alp_pkg::OP_GAIN1;
                state_next = S_GAIN2;
            end
            S_GAIN2:
            begin
                cmd.op     = alp_pkg::OP_GAIN2;
                state_next = S_ADV;
            end
            S_ADV:
            begin
                cmd.op     = alp_pkg::OP_ADV;
                state_next = status.need_wrap ? S_WRAP_WAIT : S_OUT;
            end
            S_WRAP_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = alp_pkg::OP_WRAP;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op     = alp_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            S_T_CHECK:
            begin
                state_next = status.sync_ok ? S_T_MUL1 : S_IDLE;
            end
            S_T_MUL1:
            begin
                cmd.op     = alp_pkg::OP_T_MUL1;
                state_next = S_T_MUL2;
            end
            S_T_MUL2:
            begin
                cmd.op     = alp_pkg::OP_T_MUL2;
                state_next = S_T_DIV1;
            end
            S_T_DIV1:
            begin
                cmd.op     = alp_pkg::OP_T_DIV1;
                state_next = S_T_W1;
            end
            S_T_W1:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = alp_pkg::OP_T_DIV2;
                    state_next = S_T_W2;
                end
            end
            S_T_W2:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = alp_pkg::OP_T_DIV3;
                    state_next = S_T_W3;
                end
            end
            S_T_W3:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = alp_pkg::OP_T_SET;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.op == alp_pkg::OP_OUT)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
endmodule

// ===== rtl/audio_loop_playhead.sv =====
// audio_loop_playhead: looping stereo sample player, top level.
// Depends on alp_pkg, alp_if, alp_ctrl, alp_datapath (with alp_div).
//
//  channel | dir | payload                                         | word
//  --------+-----+-------------------------------------------------+------------------
//  req     | in  | kind, load_index, load_left/right, beat, tempo  | one command
//  rsp     | out | out_left, out_right                             | one frame per tick
//  cfg     | in  | index (3b), data (24b)                          | one register write
//
// One word at a time. Load and rewind go through dispatch to their own step. A tick
// also runs the wrap modulo on the shared divider when the step crosses a loop bound. Align
// runs three divisions on the divider (beat quotient, modulo span, fraction), and it is
// dropped after its check when it is ignored. Reset (async, active low) clears config to defaults and the
// position to 0; the frame memory is not cleared. cfg is always ready. A
// finished frame sits in the rsp register while new words are taken; only the
// next tick's output step waits for it to drain.
`timescale 1ns / 1ps
module audio_loop_playhead #(
    parameter int MEM_DEPTH = alp_pkg::MEM_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    alp_in_if.sink          req,
    alp_out_if.source       rsp,
    alp_cfg_if.sink         cfg
);
    alp_pkg::cmd_t    cmd;
    alp_pkg::status_t status;
    logic             cfg_we;

    // register writes take effect in the cycle after valid, no backpressure
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    alp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    alp_datapath #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .kind          (req.kind),
        .load_index    (req.load_index),
        .load_left     (req.load_left),
        .load_right    (req.load_right),
        .beat_position (req.beat_position),
        .tempo         (req.tempo),
        .out_left      (rsp.out_left),
        .out_right     (rsp.out_right)
    );
endmodule

// ===== rtl/alp_checker.sv =====
// alp_checker: port-level assertions for audio_loop_playhead, bound to it.
// Depends on alp_pkg for widths.
`timescale 1ns / 1ps
module alp_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                req_valid,
    input logic                                req_ready,
    input logic                                rsp_valid,
    input logic                                rsp_ready,
    input logic signed [alp_pkg::SAMPLE_W-1:0] rsp_left,
    input logic signed [alp_pkg::SAMPLE_W-1:0] rsp_right
);
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp dropped before taken");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_left) && $stable(rsp_right))
        else $error("rsp word changed while stalled");

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second word taken while busy");

    a_rsp_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("result appeared while idle");
endmodule

bind audio_loop_playhead alp_checker u_alp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_left  (rsp.out_left),
    .rsp_right (rsp.out_right)
);
